### sv/tbpr_pkg.sv
// shared types and constants for the tablet event to pointer report block
`default_nettype none

package tbpr_pkg;

  localparam int unsigned TYPE_W    = 16;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned BTN_W     = 3;
  localparam int unsigned AXIS_W    = 15;
  localparam int unsigned PRODUCT_W = AXIS_W + SIZE_W;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TYPE_W-1:0] TYPE_SYN = 16'h0000;
  localparam logic [TYPE_W-1:0] TYPE_KEY = 16'h0001;
  localparam logic [TYPE_W-1:0] TYPE_ABS = 16'h0003;

  localparam logic [CODE_W-1:0] CODE_AXIS_X     = 16'h0000;
  localparam logic [CODE_W-1:0] CODE_AXIS_Y     = 16'h0001;
  localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 16'h0000;
  localparam logic [CODE_W-1:0] CODE_BTN_LEFT   = 16'h0110;
  localparam logic [CODE_W-1:0] CODE_BTN_RIGHT  = 16'h0111;
  localparam logic [CODE_W-1:0] CODE_BTN_MIDDLE = 16'h0112;

  localparam logic [VALUE_W-1:0] AXIS_MAX   = 32'd32767;
  localparam logic [SIZE_W-1:0]  SCREEN_MAX = 13'd4096;
  localparam logic [SIZE_W-1:0]  SIZE_MIN   = 13'd1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_AXIS_X,
    OP_AXIS_Y,
    OP_BUTTON,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [BTN_W-1:0]     btn;
    logic                 pressed;
    logic                 over;
    logic [SIZE_W-1:0]    size;
    logic [PRODUCT_W-1:0] product;
  } item_t;

endpackage

`default_nettype wire

### sv/tbpr_scale.sv
// input register, event decode and axis times screen size product register
`default_nettype none

module tbpr_scale (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tbpr_pkg::TYPE_W-1:0]  event_type,
  input  wire logic [tbpr_pkg::CODE_W-1:0]  event_code,
  input  wire logic [tbpr_pkg::VALUE_W-1:0] event_value,
  input  wire logic [tbpr_pkg::SIZE_W-1:0]  screen_width,
  input  wire logic [tbpr_pkg::SIZE_W-1:0]  screen_height,
  output logic                              item_valid,
  output tbpr_pkg::item_t                   item,
  input  wire logic                         item_ready
);

  logic                              ev_valid;
  logic [tbpr_pkg::TYPE_W-1:0]       ev_type;
  logic [tbpr_pkg::CODE_W-1:0]       ev_code;
  logic [tbpr_pkg::VALUE_W-1:0]      ev_value;
  logic                              prod_ready;
  tbpr_pkg::item_t                   item_next;
  logic [tbpr_pkg::SIZE_W-1:0]       raw_size;

  assign prod_ready = !item_valid || item_ready;
  assign in_ready   = !ev_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        ev_valid <= in_valid;
      end
      if (prod_ready) begin
        item_valid <= ev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_type  <= event_type;
      ev_code  <= event_code;
      ev_value <= event_value;
    end
    if (ev_valid && prod_ready) begin
      item <= item_next;
    end
  end

  always_comb begin
    item_next         = '0;
    item_next.op      = tbpr_pkg::OP_NONE;
    item_next.pressed = |ev_value;
    item_next.over    = ev_value >= tbpr_pkg::AXIS_MAX;
    case (ev_type)
      tbpr_pkg::TYPE_ABS: begin
        if (ev_code == tbpr_pkg::CODE_AXIS_X) begin
          item_next.op = tbpr_pkg::OP_AXIS_X;
        end else if (ev_code == tbpr_pkg::CODE_AXIS_Y) begin
          item_next.op = tbpr_pkg::OP_AXIS_Y;
        end
      end
      tbpr_pkg::TYPE_KEY: begin
        if (ev_code == tbpr_pkg::CODE_BTN_LEFT) begin
          item_next.op  = tbpr_pkg::OP_BUTTON;
          item_next.btn = 3'b001;
        end else if (ev_code == tbpr_pkg::CODE_BTN_RIGHT) begin
          item_next.op  = tbpr_pkg::OP_BUTTON;
          item_next.btn = 3'b010;
        end else if (ev_code == tbpr_pkg::CODE_BTN_MIDDLE) begin
          item_next.op  = tbpr_pkg::OP_BUTTON;
          item_next.btn = 3'b100;
        end
      end
      tbpr_pkg::TYPE_SYN: begin
        if (ev_code == tbpr_pkg::CODE_SYN_REPORT) begin
          item_next.op = tbpr_pkg::OP_REPORT;
        end
      end
      default: begin
        item_next.op = tbpr_pkg::OP_NONE;
      end
    endcase

    // out-of-range sizes are pinned to 1 .. 4096
    raw_size = (item_next.op == tbpr_pkg::OP_AXIS_Y) ? screen_height : screen_width;
    if (raw_size == '0) begin
      item_next.size = tbpr_pkg::SIZE_MIN;
    end else if (raw_size > tbpr_pkg::SCREEN_MAX) begin
      item_next.size = tbpr_pkg::SCREEN_MAX;
    end else begin
      item_next.size = raw_size;
    end

    item_next.product = tbpr_pkg::PRODUCT_W'(ev_value[tbpr_pkg::AXIS_W-1:0])
                      * tbpr_pkg::PRODUCT_W'(item_next.size);
  end

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (item.size != '0 && item.size <= tbpr_pkg::SCREEN_MAX))
    else $error("effective size out of range");

  a_button_onehot: assert property (@(posedge clk) disable iff (rst)
    item_valid && item.op == tbpr_pkg::OP_BUTTON |-> $onehot(item.btn))
    else $error("button select not one-hot");

endmodule

`default_nettype wire

### sv/tbpr_track.sv
// divide by 32767, pending and button state, report output register
`default_nettype none

module tbpr_track (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  input  wire tbpr_pkg::item_t              item,
  output logic                              item_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tbpr_pkg::COORD_W-1:0]      pointer_x,
  output logic [tbpr_pkg::COORD_W-1:0]      pointer_y,
  output logic [tbpr_pkg::BTN_W-1:0]        button_mask
);

  localparam int unsigned REM_W = tbpr_pkg::AXIS_W + 1;

  logic                           out_free;
  logic                           adv;
  logic                           is_report;
  logic [tbpr_pkg::SIZE_W-1:0]    quot0;
  logic [REM_W-1:0]               rem;
  logic [tbpr_pkg::SIZE_W-1:0]    quot;
  logic [tbpr_pkg::SIZE_W-1:0]    pos;
  logic [tbpr_pkg::COORD_W-1:0]   pending_x;
  logic [tbpr_pkg::COORD_W-1:0]   pending_y;
  logic                           pending_x_valid;
  logic                           pending_y_valid;
  logic [tbpr_pkg::BTN_W-1:0]     held_buttons;

  assign is_report  = item.op == tbpr_pkg::OP_REPORT;
  assign out_free   = !out_valid || out_ready;
  assign item_ready = !is_report || out_free;
  assign adv        = item_valid && item_ready;

  // x / (2^15 - 1): high part plus one correction step
  always_comb begin
    quot0 = item.product[tbpr_pkg::PRODUCT_W-1:tbpr_pkg::AXIS_W];
    rem   = REM_W'(item.product[tbpr_pkg::AXIS_W-1:0]) + REM_W'(quot0);
    quot  = quot0 + tbpr_pkg::SIZE_W'(rem >= REM_W'(tbpr_pkg::AXIS_MAX));
    pos   = item.over ? (item.size - tbpr_pkg::SIZE_MIN) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      pending_x       <= '0;
      pending_y       <= '0;
      pending_x_valid <= 1'b0;
      pending_y_valid <= 1'b0;
      held_buttons    <= '0;
      pointer_x       <= '0;
      pointer_y       <= '0;
      button_mask     <= '0;
    end else begin
      if (adv && is_report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        case (item.op)
          tbpr_pkg::OP_AXIS_X: begin
            pending_x       <= pos[tbpr_pkg::COORD_W-1:0];
            pending_x_valid <= 1'b1;
          end
          tbpr_pkg::OP_AXIS_Y: begin
            pending_y       <= pos[tbpr_pkg::COORD_W-1:0];
            pending_y_valid <= 1'b1;
          end
          tbpr_pkg::OP_BUTTON: begin
            if (item.pressed) begin
              held_buttons <= held_buttons | item.btn;
            end else begin
              held_buttons <= held_buttons & ~item.btn;
            end
          end
          tbpr_pkg::OP_REPORT: begin
            // output register doubles as the last reported position
            if (pending_x_valid) begin
              pointer_x <= pending_x;
            end
            if (pending_y_valid) begin
              pointer_y <= pending_y;
            end
            button_mask     <= held_buttons;
            pending_x_valid <= 1'b0;
            pending_y_valid <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    adv && is_report |=> !pending_x_valid && !pending_y_valid)
    else $error("pending marks not cleared by report");

  a_pending_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pending_x_valid) |-> $past(adv && item.op == tbpr_pkg::OP_AXIS_X))
    else $error("pending x set without an x event");

  a_x_in_screen: assert property (@(posedge clk) disable iff (rst)
    adv && item.op == tbpr_pkg::OP_AXIS_X |=>
      tbpr_pkg::SIZE_W'(pending_x) < $past(item.size))
    else $error("scaled x beyond screen");

  a_hold_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && item_valid && is_report |-> !item_ready)
    else $error("report taken while output is blocked");

endmodule

`default_nettype wire

### sv/tablet_event_to_pointer_report.sv
// top level: tablet event records in, pointer reports out
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  event_type, event_code, event_value
//  m_        out        m_tvalid / m_tready  pointer_x, pointer_y, button_mask
//  cfg_      in         cfg_wr_en            screen_width (0), screen_height (1)
//
// one item a cycle unless stalled; a sync item's report is offered on m_ from the output register
// stages: input register, size product register, divide and state into output register
// reset clears valids, pending and button state, last position, sizes to 1024 x 768
// a report waiting on m_tready stalls the next sync item and all behind it
`default_nettype none

module tablet_event_to_pointer_report (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [63:0]                     s_tdata,   // event_type, event_code, event_value
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // pointer_x, pointer_y, button_mask, zero
  input  wire logic                            cfg_wr_en,
  input  wire logic [tbpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbpr_pkg::SIZE_W-1:0]     cfg_wdata
);

  logic [tbpr_pkg::SIZE_W-1:0]  screen_width;
  logic [tbpr_pkg::SIZE_W-1:0]  screen_height;
  logic                         item_valid;
  logic                         item_ready;
  tbpr_pkg::item_t              item;
  logic [tbpr_pkg::COORD_W-1:0] pointer_x;
  logic [tbpr_pkg::COORD_W-1:0] pointer_y;
  logic [tbpr_pkg::BTN_W-1:0]   button_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tbpr_pkg::WIDTH_RESET;
      screen_height <= tbpr_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == tbpr_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_wdata;
      end
      if (cfg_index == tbpr_pkg::REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_wdata;
      end
    end
  end

  tbpr_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .event_type    (s_tdata[15:0]),
    .event_code    (s_tdata[31:16]),
    .event_value   (s_tdata[63:32]),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready)
  );

  tbpr_track u_track (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .button_mask (button_mask)
  );

  assign m_tdata = {5'b0, button_mask, pointer_y, pointer_x};

endmodule

`default_nettype wire
